// ===== hdl/bresenham_line_stepper_top_defines.svh =====
// Assertion macros used by the asserting file of the line stepper.
`ifndef BRESENHAM_LINE_STEPPER_TOP_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BLS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bls_pkg.sv =====
package bls_pkg;

	// Glyph byte width.
	localparam int GLYPH_BITS = 8;

	// Command carried on the input side band.
	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_STEP = 1'b1
	} cmd_t;

endpackage

// ===== hdl/bls_core.sv =====
module bls_core
	import bls_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  cmd_t                  command,
	input  logic [COORD_BITS-1:0] row_start,
	input  logic [COORD_BITS-1:0] col_start,
	input  logic [COORD_BITS-1:0] row_end,
	input  logic [COORD_BITS-1:0] col_end,
	input  logic [GLYPH_BITS-1:0] glyph,
	output logic                  res_valid,
	output logic [COORD_BITS-1:0] res_row,
	output logic [COORD_BITS-1:0] res_col,
	output logic [GLYPH_BITS-1:0] res_glyph,
	output logic                  res_last,
	output logic                  active
);

	// Position can sit one unit outside the coordinate range after a load.
	localparam int CW = COORD_BITS + 2;
	// Doubled delta reaches 2^(COORD_BITS+1).
	localparam int DW = COORD_BITS + 2;
	localparam int EW = COORD_BITS + 4;

	logic signed [CW-1:0]   cur_col_q, cur_row_q;
	logic [COORD_BITS-1:0]  end_col_q, end_row_q;
	logic [DW-1:0]          twice_dx_q, twice_dy_q;
	logic                   col_dir_neg_q, row_dir_neg_q;
	logic signed [EW-1:0]   error_q;
	logic                   col_major_q;
	logic                   active_q;
	logic [GLYPH_BITS-1:0]  glyph_q;

	logic                   c_gt, c_lt, r_gt, r_lt;
	logic signed [CW-1:0]   cs_ext, rs_ext, ce_ext, re_ext;
	logic signed [CW-1:0]   ld_col, ld_row;
	logic [COORD_BITS-1:0]  c_abs, r_abs;
	logic [COORD_BITS:0]    ld_dx, ld_dy;
	logic [DW-1:0]          ld_tdx, ld_tdy;
	logic                   ld_major;
	logic signed [EW-1:0]   ld_err;
	logic                   ld_active;

	logic signed [CW-1:0]   col_adv, row_adv, st_col, st_row;
	logic signed [CW-1:0]   end_col_ext, end_row_ext;
	logic signed [EW-1:0]   tdx_e, tdy_e, st_err;
	logic                   err_nonneg, st_last;

	// Line setup from a load item.
	always_comb begin
		cs_ext = CW'({2'b00, col_start});
		rs_ext = CW'({2'b00, row_start});
		ce_ext = CW'({2'b00, col_end});
		re_ext = CW'({2'b00, row_end});
		c_gt   = col_end > col_start;
		c_lt   = col_end < col_start;
		r_gt   = row_end > row_start;
		r_lt   = row_end < row_start;
		// Pull each start coordinate one unit away from its end.
		ld_col = c_gt ? cs_ext - CW'(1) : (c_lt ? cs_ext + CW'(1) : cs_ext);
		ld_row = r_gt ? rs_ext - CW'(1) : (r_lt ? rs_ext + CW'(1) : rs_ext);
		c_abs  = c_gt ? col_end - col_start : col_start - col_end;
		r_abs  = r_gt ? row_end - row_start : row_start - row_end;
		ld_dx  = {1'b0, c_abs} + (COORD_BITS+1)'(c_gt | c_lt);
		ld_dy  = {1'b0, r_abs} + (COORD_BITS+1)'(r_gt | r_lt);
		ld_tdx = {ld_dx, 1'b0};
		ld_tdy = {ld_dy, 1'b0};
		ld_major = ld_tdx > ld_tdy;
		if (ld_major) begin
			ld_err    = $signed(EW'({2'b00, ld_tdy})) - $signed(EW'({3'b000, ld_dx}));
			ld_active = ld_col != ce_ext;
		end else begin
			ld_err    = $signed(EW'({2'b00, ld_tdx})) - $signed(EW'({3'b000, ld_dy}));
			ld_active = ld_row != re_ext;
		end
	end

	// One Bresenham step from the stored line state.
	always_comb begin
		col_adv     = col_dir_neg_q ? cur_col_q - CW'(1) : cur_col_q + CW'(1);
		row_adv     = row_dir_neg_q ? cur_row_q - CW'(1) : cur_row_q + CW'(1);
		end_col_ext = CW'({2'b00, end_col_q});
		end_row_ext = CW'({2'b00, end_row_q});
		tdx_e       = $signed(EW'({2'b00, twice_dx_q}));
		tdy_e       = $signed(EW'({2'b00, twice_dy_q}));
		err_nonneg  = !error_q[EW-1];
		if (col_major_q) begin
			st_col  = col_adv;
			st_row  = err_nonneg ? row_adv : cur_row_q;
			st_err  = error_q - (err_nonneg ? tdx_e : '0) + tdy_e;
			st_last = col_adv == end_col_ext;
		end else begin
			st_row  = row_adv;
			st_col  = err_nonneg ? col_adv : cur_col_q;
			st_err  = error_q - (err_nonneg ? tdy_e : '0) + tdx_e;
			st_last = row_adv == end_row_ext;
		end
	end

	assign res_valid = accept && (command == CMD_STEP) && active_q;
	assign res_row   = st_row[COORD_BITS-1:0];
	assign res_col   = st_col[COORD_BITS-1:0];
	assign res_glyph = glyph_q;
	assign res_last  = st_last;
	assign active    = active_q;

	// Line state: a load replaces it, a step on an active line advances it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q     <= '0;
			cur_row_q     <= '0;
			end_col_q     <= '0;
			end_row_q     <= '0;
			twice_dx_q    <= '0;
			twice_dy_q    <= '0;
			col_dir_neg_q <= 1'b0;
			row_dir_neg_q <= 1'b0;
			error_q       <= '0;
			col_major_q   <= 1'b0;
			active_q      <= 1'b0;
			glyph_q       <= '0;
		end else if (accept) begin
			if (command == CMD_LOAD) begin
				cur_col_q     <= ld_col;
				cur_row_q     <= ld_row;
				end_col_q     <= col_end;
				end_row_q     <= row_end;
				twice_dx_q    <= ld_tdx;
				twice_dy_q    <= ld_tdy;
				col_dir_neg_q <= c_lt;
				row_dir_neg_q <= r_lt;
				error_q       <= ld_err;
				col_major_q   <= ld_major;
				active_q      <= ld_active;
				glyph_q       <= glyph;
			end else if (active_q) begin
				cur_col_q <= st_col;
				cur_row_q <= st_row;
				error_q   <= st_err;
				active_q  <= !st_last;
			end
		end
	end

endmodule

// ===== hdl/bls_out_skid.sv =====
module bls_out_skid #(
	parameter int W = 33
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic         main_valid_q, skid_valid_q;
	logic [W-1:0] main_data_q, skid_data_q;
	logic         pop;

	assign pop       = main_valid_q && out_ready;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_data_q;

	// Valid flags: the skid entry only fills when the main entry is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!main_valid_q || pop) begin
			main_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves with the flags and needs no reset.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_data_q <= skid_data_q;
			end
		end else if (!main_valid_q || pop) begin
			main_data_q <= push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

endmodule

// ===== hdl/bresenham_line_stepper_top.sv =====
// Bresenham line stepper.
// Input stream (s_*): one item per handshake. s_tuser is the command:
// load latches start and end row/column plus a glyph byte and emits
// nothing; step advances one unit along the major axis and emits one
// point while a line is active. A step with no active line, or a load
// whose start equals its end, gives no output item.
// Output stream (m_*): row, column and glyph in m_tdata, m_tlast high on
// the end point of the line.
// Each accepted step's point is registered in the output buffer before it
// is shown on m_tvalid. Throughput is one item per cycle while s_tready is
// high: the step is one add, compare and subtract on the stored line state.
// A two-entry output buffer lets the block take one more item while a
// point waits; s_tready falls only when both entries are held by a
// stalled receiver and rises again as soon as m_tready takes one.
// Reset (arst_n low) clears the line state and empties the output buffer;
// no line is active afterwards.
module bresenham_line_stepper_top
	import bls_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// row_start, col_start, row_end, col_end, glyph; zero padded to bytes
	input  logic [((4*COORD_BITS+GLYPH_BITS+7)/8)*8-1:0] s_tdata,
	// command
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// point_row, point_col, point_glyph; zero padded to bytes
	output logic [((2*COORD_BITS+GLYPH_BITS+7)/8)*8-1:0] m_tdata,
	output logic                  m_tlast
);

	localparam int OUT_W  = ((2*COORD_BITS+GLYPH_BITS+7)/8)*8;
	localparam int PAY_W  = 2*COORD_BITS + GLYPH_BITS;
	localparam int BUF_W  = PAY_W + 1;

	logic                  s_accept;
	cmd_t                  command;
	logic                  res_valid, res_last, line_active, buf_full;
	logic [COORD_BITS-1:0] res_row, res_col;
	logic [GLYPH_BITS-1:0] res_glyph;
	logic [BUF_W-1:0]      buf_out;

	assign s_accept = s_tvalid && s_tready;
	assign command  = cmd_t'(s_tuser);
	assign s_tready = !buf_full;

	// Line state and step arithmetic.
	bls_core #(
		.COORD_BITS(COORD_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (s_accept),
		.command   (command),
		.row_start (s_tdata[COORD_BITS-1:0]),
		.col_start (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.row_end   (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
		.col_end   (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
		.glyph     (s_tdata[4*COORD_BITS+GLYPH_BITS-1:4*COORD_BITS]),
		.res_valid (res_valid),
		.res_row   (res_row),
		.res_col   (res_col),
		.res_glyph (res_glyph),
		.res_last  (res_last),
		.active    (line_active)
	);

	// Registered output with one skid entry.
	bls_out_skid #(
		.W(BUF_W)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data ({res_last, res_glyph, res_col, res_row}),
		.full      (buf_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (buf_out)
	);

	assign m_tdata = OUT_W'(buf_out[PAY_W-1:0]);
	assign m_tlast = buf_out[PAY_W];

	`include "bresenham_line_stepper_top_defines.svh"

	// A point is produced only by an accepted step.
	`BLS_ASSERT_SAME(a_point_from_step, res_valid, s_accept && (command == CMD_STEP), "point without an accepted step")
	// The line is finished right after its end point.
	`BLS_ASSERT_NEXT(a_end_clears_line, res_valid && res_last, !line_active, "line still active after its end point")
	// Back pressure only while a point is waiting at the output.
	`BLS_ASSERT_SAME(a_stall_has_output, !s_tready, m_tvalid, "input stalled with an empty output")
	// A load never produces a point.
	`BLS_ASSERT_SAME(a_load_silent, s_accept && (command == CMD_LOAD), !res_valid, "load produced a point")

endmodule
